>>> rtl/core/circular_buffer_deque_defines.svh
// Assertion macros for the circular buffer deque.
`ifndef CIRCULAR_BUFFER_DEQUE_DEFINES_SVH
`define CIRCULAR_BUFFER_DEQUE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define CBD_ASSERT_NOW(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("cbd: same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define CBD_ASSERT_NEXT(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("cbd: next-cycle check failed");

`endif

>>> rtl/core/cbd_pkg.sv
// Shared types and constants for the circular buffer deque.
package cbd_pkg;

	localparam int DEF_MAX_DEPTH = 16;
	localparam int DEF_WORD_BITS = 32;
	localparam int VALUE_BITS    = 32;
	localparam int CAP_BITS      = 5;
	localparam int CAP_RESET     = 16;
	localparam int ACTION_BITS   = 3;

	localparam logic [ACTION_BITS-1:0] ACT_PUSH_BACK  = 3'd0;
	localparam logic [ACTION_BITS-1:0] ACT_PUSH_FRONT = 3'd1;
	localparam logic [ACTION_BITS-1:0] ACT_POP_BACK   = 3'd2;
	localparam logic [ACTION_BITS-1:0] ACT_POP_FRONT  = 3'd3;
	localparam logic [ACTION_BITS-1:0] ACT_PEEK_BACK  = 3'd4;
	localparam logic [ACTION_BITS-1:0] ACT_PEEK_FRONT = 3'd5;
	localparam logic [ACTION_BITS-1:0] ACT_QUERY      = 3'd6;

	typedef struct packed {
		logic [ACTION_BITS-1:0]       action;
		logic signed [VALUE_BITS-1:0] push_value;
	} in_beat_t;

	typedef struct packed {
		logic                         success;
		logic signed [VALUE_BITS-1:0] read_value;
		logic                         now_empty;
	} out_beat_t;

	typedef struct packed {
		logic exec;
		logic load;
	} cmd_t;

endpackage

>>> rtl/core/cbd_ctrl.sv
// Controller state machine: input acceptance, result load and output valid.
module cbd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output cbd_pkg::cmd_t cmd
);

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign cmd.exec  = in_valid && (state_q == ST_IDLE);
	assign cmd.load  = (state_q == ST_EXEC) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.exec) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (cmd.load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/core/cbd_datapath.sv
// Datapath: ring store, front and back pointers, entry count and result register.
module cbd_datapath #(
	parameter int MAX_DEPTH = cbd_pkg::DEF_MAX_DEPTH,
	parameter int WORD_BITS = cbd_pkg::DEF_WORD_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cbd_pkg::cmd_t                 cmd,
	input  cbd_pkg::in_beat_t             in_data,
	input  logic                          cfg_wr_en,
	input  logic [cbd_pkg::CAP_BITS-1:0]  cfg_wr_data,
	output cbd_pkg::out_beat_t            out_data
);

	localparam int PTR_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int CNT_W = PTR_W + 1;
	localparam int CW    = (CNT_W > cbd_pkg::CAP_BITS) ? CNT_W : cbd_pkg::CAP_BITS;
	localparam int VB    = cbd_pkg::VALUE_BITS;
	localparam int RESET_CAP = (cbd_pkg::CAP_RESET > MAX_DEPTH) ?
		MAX_DEPTH : cbd_pkg::CAP_RESET;
	localparam logic [WORD_BITS-1:0] WORD_ONES = '1;

	logic [WORD_BITS-1:0] mem [MAX_DEPTH];

	logic [CW-1:0]    cap_q;
	logic [PTR_W-1:0] front_q;
	logic [PTR_W-1:0] back_q;
	logic [CNT_W-1:0] cnt_q;

	logic [WORD_BITS-1:0] rdata_s1;
	logic                 ok_s1;
	logic                 fail_s1;
	logic                 hit_s1;
	logic                 empty_s1;
	cbd_pkg::out_beat_t   out_q;

	logic [cbd_pkg::ACTION_BITS-1:0] act;
	logic [WORD_BITS-1:0] word;
	logic                 full;
	logic                 empty;
	logic [PTR_W-1:0]     back_inc;
	logic [PTR_W-1:0]     back_dec;
	logic [PTR_W-1:0]     front_inc;
	logic [PTR_W-1:0]     front_dec;
	logic [PTR_W-1:0]     back_n;
	logic [PTR_W-1:0]     front_n;
	logic [CNT_W-1:0]     cnt_n;
	logic                 wr_en;
	logic [PTR_W-1:0]     wr_addr;
	logic                 rd_en;
	logic [PTR_W-1:0]     rd_addr;
	logic                 ok;
	logic                 fail;
	logic [CW-1:0]        cfg_ext;
	logic [CW-1:0]        cap_wr;

	always_comb begin
		cfg_ext = CW'(cfg_wr_data);
		if (cfg_ext == '0) begin
			cap_wr = CW'(1);
		end else if (cfg_ext > CW'(MAX_DEPTH)) begin
			cap_wr = CW'(MAX_DEPTH);
		end else begin
			cap_wr = cfg_ext;
		end
	end

	always_comb begin
		act   = in_data.action;
		word  = WORD_BITS'($unsigned(in_data.push_value));
		full  = CW'(cnt_q) >= cap_q;
		empty = (cnt_q == '0);

		back_inc  = (CW'(back_q) + CW'(1) >= cap_q) ? '0 : back_q + PTR_W'(1);
		front_inc = (CW'(front_q) + CW'(1) >= cap_q) ? '0 : front_q + PTR_W'(1);
		back_dec  = (back_q == '0 || CW'(back_q) >= cap_q) ?
			PTR_W'(cap_q - CW'(1)) : back_q - PTR_W'(1);
		front_dec = (front_q == '0 || CW'(front_q) >= cap_q) ?
			PTR_W'(cap_q - CW'(1)) : front_q - PTR_W'(1);

		back_n  = back_q;
		front_n = front_q;
		cnt_n   = cnt_q;
		wr_en   = 1'b0;
		wr_addr = back_q;
		rd_en   = 1'b0;
		rd_addr = back_dec;
		ok      = 1'b0;
		fail    = 1'b0;

		case (act)
			cbd_pkg::ACT_PUSH_BACK: begin
				if (!full) begin
					wr_en   = 1'b1;
					wr_addr = back_q;
					back_n  = back_inc;
					cnt_n   = cnt_q + CNT_W'(1);
					ok      = 1'b1;
				end
			end
			cbd_pkg::ACT_PUSH_FRONT: begin
				if (!full) begin
					wr_en   = 1'b1;
					wr_addr = front_q;
					front_n = front_dec;
					cnt_n   = cnt_q + CNT_W'(1);
					ok      = 1'b1;
				end
			end
			cbd_pkg::ACT_POP_BACK, cbd_pkg::ACT_PEEK_BACK: begin
				if (empty) begin
					fail = 1'b1;
				end else begin
					rd_en   = 1'b1;
					rd_addr = back_dec;
					ok      = 1'b1;
					if (act == cbd_pkg::ACT_POP_BACK) begin
						back_n = back_dec;
						cnt_n  = cnt_q - CNT_W'(1);
					end
				end
			end
			cbd_pkg::ACT_POP_FRONT, cbd_pkg::ACT_PEEK_FRONT: begin
				if (empty) begin
					fail = 1'b1;
				end else begin
					rd_en   = 1'b1;
					rd_addr = front_inc;
					ok      = 1'b1;
					if (act == cbd_pkg::ACT_POP_FRONT) begin
						front_n = front_inc;
						cnt_n   = cnt_q - CNT_W'(1);
					end
				end
			end
			cbd_pkg::ACT_QUERY: begin
				ok = 1'b1;
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CW'(RESET_CAP);
			front_q <= PTR_W'(RESET_CAP - 1);
			back_q  <= '0;
			cnt_q   <= '0;
		end else if (cfg_wr_en) begin
			cap_q   <= cap_wr;
			front_q <= PTR_W'(cap_wr - CW'(1));
			back_q  <= '0;
			cnt_q   <= '0;
		end else if (cmd.exec) begin
			front_q <= front_n;
			back_q  <= back_n;
			cnt_q   <= cnt_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (wr_en) begin
				mem[wr_addr] <= word;
			end
			if (rd_en) begin
				rdata_s1 <= mem[rd_addr];
			end
			ok_s1    <= ok;
			fail_s1  <= fail;
			hit_s1   <= rd_en;
			empty_s1 <= (cnt_n == '0);
		end
		if (cmd.load) begin
			out_q.success   <= ok_s1;
			out_q.now_empty <= empty_s1;
			if (hit_s1) begin
				out_q.read_value <= VB'(rdata_s1);
			end else if (fail_s1) begin
				out_q.read_value <= VB'(WORD_ONES);
			end else begin
				out_q.read_value <= '0;
			end
		end
	end

	assign out_data = out_q;

endmodule

>>> rtl/core/circular_buffer_deque.sv
// Top level of the circular buffer deque: controller, datapath and checks.
//
//   channel  direction  handshake            payload
//   in       to block   in_valid / in_ready  in_data  (action, push_value)
//   out      from block out_valid / out_ready out_data (success, read_value, now_empty)
//   cfg      to block   cfg_wr_en            cfg_wr_data (capacity)
//
// For each item, the accept cycle updates pointers and count and issues the
// store access; the ST_EXEC state then loads the registered read word into
// the output register once the output can take it.
// A new beat is taken while an earlier result waits at the output.
// Reset empties the deque at capacity min(16, MAX_DEPTH); store contents undefined.
// A stalled output holds the result in its register and pauses the next item.
`include "circular_buffer_deque_defines.svh"

module circular_buffer_deque #(
	parameter int MAX_DEPTH = cbd_pkg::DEF_MAX_DEPTH,
	parameter int WORD_BITS = cbd_pkg::DEF_WORD_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  cbd_pkg::in_beat_t            in_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output cbd_pkg::out_beat_t           out_data,
	input  logic                         cfg_wr_en,
	input  logic [cbd_pkg::CAP_BITS-1:0] cfg_wr_data
);

	localparam int VB = cbd_pkg::VALUE_BITS;
	localparam logic [WORD_BITS-1:0] WORD_ONES = '1;
	localparam logic [VB-1:0] FAIL_VALUE = VB'(WORD_ONES);

	cbd_pkg::cmd_t cmd;

	cbd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	cbd_datapath #(
		.MAX_DEPTH (MAX_DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.in_data     (in_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.out_data    (out_data)
	);

	`CBD_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)
	`CBD_ASSERT_NEXT(a_load_shows, cmd.load, out_valid)
	`CBD_ASSERT_NOW(a_fail_value, out_valid && !out_data.success, out_data.read_value == FAIL_VALUE || out_data.read_value == '0)

endmodule
